[design/fbf_pkg.sv]
// Shared types, codes and helper functions for the dirty-block frame flusher.
package fbf_pkg;

    // Operation codes on the mode field
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_RENDER_ENABLE = 1'b0;
    localparam logic CFG_SCROLL_HOLD   = 1'b1;

    // Image-write header
    localparam int         HDR_LEN      = 13;
    localparam logic [7:0] HDR_UNIT     = 8'h1F;
    localparam logic [7:0] HDR_GROUP    = 8'h28;
    localparam logic [7:0] HDR_FUNC     = 8'h64;
    localparam logic [7:0] HDR_IMAGE    = 8'h21;
    localparam logic [7:0] HDR_ZERO     = 8'h00;
    localparam logic [7:0] HDR_FORMAT   = 8'h01;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_WR_UPDATE,
        ST_TX_PICK,
        ST_TX_READ,
        ST_TX_EMIT
    } fbf_state_t;

    typedef struct packed {
        logic clr_write;
        logic capture;
        logic wr_read;
        logic wr_update;
        logic tx_pick;
        logic tx_read;
        logic tx_emit;
    } fbf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_write;
        logic wr_ok;
        logic is_tick;
        logic tick_go;
    } fbf_status_t;

    // Header byte at position idx (0..12); multi-byte fields go low byte first.
    function automatic logic [7:0] header_byte(
        input logic [3:0]  idx,
        input logic [15:0] xpos,
        input logic [15:0] width,
        input logic [15:0] height
    );
        logic [7:0] b;
        case (idx)
            4'd0:    b = HDR_UNIT;
            4'd1:    b = HDR_GROUP;
            4'd2:    b = HDR_FUNC;
            4'd3:    b = HDR_IMAGE;
            4'd4:    b = xpos[7:0];
            4'd5:    b = xpos[15:8];
            4'd6:    b = HDR_ZERO;
            4'd7:    b = HDR_ZERO;
            4'd8:    b = width[7:0];
            4'd9:    b = width[15:8];
            4'd10:   b = height[7:0];
            4'd11:   b = height[15:8];
            default: b = HDR_FORMAT;
        endcase
        return b;
    endfunction

endpackage

[design/framebuffer_dirty_block_flusher_core.sv]
// Top level of the dirty-block frame flusher: sequencer plus datapath.
//
// Usage:
//   Command channel: drive mode and the operand ports with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   Mode pixel and mode byte update the frame store and mark the block dirty
//   when the byte really changes. Mode bus tick sends, if allowed, one byte of
//   the 13-byte header plus block data sequence for the lowest dirty block.
//   Result: result_strobe is high for one cycle with bus_byte, sent_block and
//   last_of_block. The receiver cannot stall; it must take it that cycle.
//   Flow: a write that lands in the store keeps busy high after acceptance
//   through the store read and the read-modify-write. A tick that sends
//   keeps busy high through dispatch, block pick, store read and emit; the
//   strobe is high in the cycle in which busy drops. Any other transaction
//   (unused mode, address off the store, tick that sends nothing) ends after
//   the dispatch step. Items are served one at a time.
//   Reset: the frame store is cleared by a pass over all FRAME_BYTES bytes
//   (2048 by default), one byte per cycle; busy stays high during it.
//   Config: cfg_ready is always high; writes go through at any time, but must
//   only be issued while the block is idle.
module framebuffer_dirty_block_flusher_core #(
    parameter int FRAME_BYTES = 2048,
    parameter int BLOCK_BYTES = 128,
    parameter int BLOCK_COUNT = 16,
    parameter int PAGE_BYTES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  pixel_x,
    input  logic [5:0]  pixel_y,
    input  logic        pixel_on,
    input  logic [11:0] byte_address,
    input  logic [7:0]  byte_value,
    input  logic        bus_busy,
    output logic        result_strobe,
    output logic [7:0]  bus_byte,
    output logic [3:0]  sent_block,
    output logic        last_of_block,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import fbf_pkg::*;

    fbf_cmd_t    cmd;
    fbf_status_t status;

    // Config registers are plain flops; never back-pressured.
    assign cfg_ready = 1'b1;

    fbf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    fbf_datapath #(
        .FRAME_BYTES (FRAME_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (mode),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_on      (pixel_on),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .bus_busy      (bus_busy),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .bus_byte      (bus_byte),
        .sent_block    (sent_block),
        .last_of_block (last_of_block)
    );

endmodule

[design/fbf_ram.sv]
// Generic single-port RAM with registered read data.
module fbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[design/fbf_ctrl.sv]
// Sequencer for the frame flusher: clearing pass, write and bus-tick flows.
module fbf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fbf_pkg::fbf_status_t status,
    output fbf_pkg::fbf_cmd_t    cmd
);
    import fbf_pkg::*;

    fbf_state_t state_reg;
    fbf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.is_write && status.wr_ok)
                begin
                    state_next = ST_WR_UPDATE;
                end
                else if (status.is_tick && status.tick_go)
                begin
                    state_next = ST_TX_PICK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR_UPDATE: state_next = ST_IDLE;
            ST_TX_PICK:   state_next = ST_TX_READ;
            ST_TX_READ:   state_next = ST_TX_EMIT;
            ST_TX_EMIT:   state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:     cmd.clr_write = 1'b1;
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_DISPATCH:  cmd.wr_read   = status.is_write && status.wr_ok;
            ST_WR_UPDATE: cmd.wr_update = 1'b1;
            ST_TX_PICK:   cmd.tx_pick   = 1'b1;
            ST_TX_READ:   cmd.tx_read   = 1'b1;
            ST_TX_EMIT:   cmd.tx_emit   = 1'b1;
            default:      busy          = 1'b1;
        endcase
    end

endmodule

[design/fbf_datapath.sv]
// Frame store, dirty mask, transfer counters and result registers.
module fbf_datapath #(
    parameter int FRAME_BYTES = 2048,
    parameter int BLOCK_BYTES = 128,
    parameter int BLOCK_COUNT = 16,
    parameter int PAGE_BYTES  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fbf_pkg::fbf_cmd_t    cmd,
    output fbf_pkg::fbf_status_t status,
    input  logic [1:0]          mode,
    input  logic [7:0]          pixel_x,
    input  logic [5:0]          pixel_y,
    input  logic                pixel_on,
    input  logic [11:0]         byte_address,
    input  logic [7:0]          byte_value,
    input  logic                bus_busy,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic                cfg_data,
    output logic                result_strobe,
    output logic [7:0]          bus_byte,
    output logic [3:0]          sent_block,
    output logic                last_of_block
);
    import fbf_pkg::*;

    localparam int AW     = $clog2(FRAME_BYTES);
    localparam int CB_W   = $clog2(BLOCK_COUNT);
    localparam int SEQ_LEN = HDR_LEN + BLOCK_BYTES;
    localparam int POS_W  = $clog2(SEQ_LEN);
    localparam int PIX_W  = 8 + $clog2(PAGE_BYTES);
    localparam int EW0    = (PIX_W > 12) ? PIX_W : 12;
    localparam int EW     = ((EW0 > AW) ? EW0 : AW) + 1;
    localparam int TW     = CB_W + $clog2(BLOCK_BYTES) + 1;
    localparam int TXW    = (TW > AW + 1) ? TW : AW + 1;
    localparam int BLK_W  = BLOCK_BYTES / PAGE_BYTES;
    localparam int BLK_H  = PAGE_BYTES * 8;
    // floor(a / BLOCK_BYTES) = (a * RECIP) >> SHIFT for every a < 2**AW
    localparam int  LB     = $clog2(BLOCK_BYTES);
    localparam int  SHIFT  = AW + LB;
    localparam int  RW     = AW + 2;
    localparam longint RECIP = ((longint'(1) << SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;

    // Captured transaction
    logic [1:0]  mode_reg;
    logic [7:0]  px_reg;
    logic [5:0]  py_reg;
    logic        pon_reg;
    logic [11:0] baddr_reg;
    logic [7:0]  bval_reg;
    logic        bbusy_reg;

    // Configuration
    logic render_enable_reg;
    logic scroll_hold_reg;

    // Control state
    logic [AW-1:0]          clr_cnt_reg;
    logic [BLOCK_COUNT-1:0] dirty_reg;
    logic [BLOCK_COUNT-1:0] dirty_next;
    logic [POS_W-1:0]       pos_reg;
    logic                   sending_reg;
    logic [CB_W-1:0]        cb_reg;
    logic [AW-1:0]          blk_reg;
    logic                   tx_ok_reg;
    logic                   strobe_reg;
    logic [7:0]             byte_out_reg;
    logic [3:0]             block_out_reg;
    logic                   last_out_reg;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // Write path
    logic [2:0]      row;
    logic [EW-1:0]   pix_addr;
    logic            pix_ok;
    logic [EW-1:0]   wr_addr;
    logic [AW+RW-1:0] recip_prod;
    logic [7:0]      bit_sel;
    logic [7:0]      new_byte;
    logic            changed;

    // Transfer path
    logic [CB_W-1:0]  pick;
    logic [TXW-1:0]   tx_addr;
    logic             hdr_phase;
    logic [15:0]      hdr_x;
    logic [7:0]       hdr_b;
    logic [CB_W+3:0]  cb_ext;
    logic             last_pos;

    fbf_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---- write address and block number ----
    assign row      = py_reg[5:3];
    assign pix_addr = EW'(px_reg) * EW'(PAGE_BYTES) + EW'(row);
    assign pix_ok   = (EW'(row) < EW'(PAGE_BYTES)) && (pix_addr < EW'(FRAME_BYTES));
    assign wr_addr  = (mode_reg == MODE_PIXEL) ? pix_addr : EW'(baddr_reg);

    assign recip_prod = (AW + RW)'(wr_addr[AW-1:0]) * (AW + RW)'(RECIP);

    always_comb
    begin
        status.clear_last = (clr_cnt_reg == AW'(FRAME_BYTES - 1));
        status.is_write   = (mode_reg == MODE_PIXEL) || (mode_reg == MODE_BYTE);
        status.wr_ok      = (mode_reg == MODE_PIXEL) ? pix_ok
                          : (wr_addr < EW'(FRAME_BYTES));
        status.is_tick    = (mode_reg == MODE_TICK);
        status.tick_go    = render_enable_reg && !bbusy_reg
                          && (sending_reg || (!scroll_hold_reg && (dirty_reg != '0)));
    end

    assign bit_sel  = 8'd1 << py_reg[2:0];
    assign new_byte = (mode_reg == MODE_BYTE) ? bval_reg
                    : (pon_reg ? (ram_rdata | bit_sel) : (ram_rdata & ~bit_sel));
    assign changed  = (new_byte != ram_rdata);

    // ---- transfer path ----
    always_comb
    begin
        pick = '0;
        for (int i = BLOCK_COUNT - 1; i >= 0; i--)
        begin
            if (dirty_reg[i])
            begin
                pick = CB_W'(i);
            end
        end
    end

    assign hdr_phase = (pos_reg < POS_W'(HDR_LEN));
    assign tx_addr   = TXW'(cb_reg) * TXW'(BLOCK_BYTES) + TXW'(pos_reg) - TXW'(HDR_LEN);
    assign hdr_x     = 16'(32'(cb_reg) * 32'(BLK_W));
    assign hdr_b     = header_byte(pos_reg[3:0], hdr_x, 16'(BLK_W), 16'(BLK_H));
    assign cb_ext    = {4'd0, cb_reg};
    assign last_pos  = (pos_reg == POS_W'(SEQ_LEN - 1));

    // ---- RAM port mux ----
    always_comb
    begin
        ram_we    = cmd.clr_write || (cmd.wr_update && changed);
        ram_wdata = cmd.clr_write ? 8'd0 : new_byte;
        if (cmd.clr_write)
        begin
            ram_addr = clr_cnt_reg;
        end
        else if (cmd.tx_read)
        begin
            ram_addr = tx_addr[AW-1:0];
        end
        else
        begin
            ram_addr = wr_addr[AW-1:0];
        end
    end

    always_comb
    begin
        dirty_next = dirty_reg;
        if (cmd.wr_update && changed && (blk_reg < AW'(BLOCK_COUNT)))
        begin
            dirty_next[blk_reg[CB_W-1:0]] = 1'b1;
        end
        if (cmd.tx_pick && !sending_reg)
        begin
            dirty_next[pick] = 1'b0;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            px_reg    <= pixel_x;
            py_reg    <= pixel_y;
            pon_reg   <= pixel_on;
            baddr_reg <= byte_address;
            bval_reg  <= byte_value;
            bbusy_reg <= bus_busy;
        end
        if (cmd.wr_read)
        begin
            blk_reg <= recip_prod[SHIFT +: AW];
        end
        if (cmd.tx_read)
        begin
            tx_ok_reg <= (tx_addr < TXW'(FRAME_BYTES));
        end
        if (cmd.tx_emit)
        begin
            byte_out_reg  <= hdr_phase ? hdr_b : (tx_ok_reg ? ram_rdata : 8'd0);
            block_out_reg <= cb_ext[3:0];
            last_out_reg  <= last_pos;
        end
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_enable_reg <= 1'b1;
            scroll_hold_reg   <= 1'b0;
            clr_cnt_reg       <= '0;
            dirty_reg         <= '0;
            pos_reg           <= '0;
            sending_reg       <= 1'b0;
            cb_reg            <= '0;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_RENDER_ENABLE)
                begin
                    render_enable_reg <= cfg_data;
                end
                else
                begin
                    scroll_hold_reg <= cfg_data;
                end
            end
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            dirty_reg <= dirty_next;
            if (cmd.tx_pick && !sending_reg)
            begin
                cb_reg      <= pick;
                sending_reg <= 1'b1;
                pos_reg     <= '0;
            end
            if (cmd.tx_emit)
            begin
                if (last_pos)
                begin
                    pos_reg     <= '0;
                    sending_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            strobe_reg <= cmd.tx_emit;
        end
    end

    assign result_strobe = strobe_reg;
    assign bus_byte      = byte_out_reg;
    assign sent_block    = block_out_reg;
    assign last_of_block = last_out_reg;

endmodule
